// ===== rtl/core/sqlkl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqlkl_pkg: shared types and constants of the SQL keyword lexer
// Token kinds, lexer modes, the keyword table and the queue entry type.
// ----------------------------------------------------------------------------
package sqlkl_pkg;

    localparam int MAX_KEYWORD_LEN_DEF = 10;
    localparam int KW_COUNT            = 60;

    localparam logic [6:0] K_IDENT   = 7'd56;
    localparam logic [6:0] K_INT     = 7'd57;
    localparam logic [6:0] K_FLOAT   = 7'd58;
    localparam logic [6:0] K_STRING  = 7'd59;
    localparam logic [6:0] K_EQ      = 7'd60;
    localparam logic [6:0] K_NEQ     = 7'd61;
    localparam logic [6:0] K_LT      = 7'd62;
    localparam logic [6:0] K_LEQ     = 7'd63;
    localparam logic [6:0] K_GT      = 7'd64;
    localparam logic [6:0] K_GEQ     = 7'd65;
    localparam logic [6:0] K_PLUS    = 7'd66;
    localparam logic [6:0] K_MINUS   = 7'd67;
    localparam logic [6:0] K_SLASH   = 7'd68;
    localparam logic [6:0] K_LPAREN  = 7'd69;
    localparam logic [6:0] K_RPAREN  = 7'd70;
    localparam logic [6:0] K_COMMA   = 7'd71;
    localparam logic [6:0] K_SEMI    = 7'd72;
    localparam logic [6:0] K_STAR    = 7'd73;
    localparam logic [6:0] K_DOT     = 7'd74;
    localparam logic [6:0] K_EOF     = 7'd75;
    localparam logic [6:0] K_UNKNOWN = 7'd76;

    localparam logic [3:0] M_IDLE    = 4'd0;
    localparam logic [3:0] M_IDENT   = 4'd1;
    localparam logic [3:0] M_NUM     = 4'd2;
    localparam logic [3:0] M_NUMDOT  = 4'd3;
    localparam logic [3:0] M_FRAC    = 4'd4;
    localparam logic [3:0] M_STR     = 4'd5;
    localparam logic [3:0] M_STRQ    = 4'd6;
    localparam logic [3:0] M_LT      = 4'd7;
    localparam logic [3:0] M_GT      = 4'd8;
    localparam logic [3:0] M_BANG    = 4'd9;
    localparam logic [3:0] M_MINUS   = 4'd10;
    localparam logic [3:0] M_COMMENT = 4'd11;

    // one token record as it leaves the block
    typedef struct packed {
        logic [6:0]  kind;
        logic [15:0] line;
        logic [15:0] column;
        logic [23:0] offset;
        logic [15:0] length;
        logic        last;
    } token_t;

    // every request from the front yields at most three tokens
    typedef struct packed {
        logic [1:0] count;
        token_t     tok0;
        token_t     tok1;
        token_t     tok2;
    } bundle_t;

    // keyword table: text padded with zeros to 10 bytes, first byte highest
    typedef struct packed {
        logic [79:0] word;
        logic [3:0]  len;
        logic [6:0]  kind;
    } kw_entry_t;

    function automatic kw_entry_t kw_rom(input logic [5:0] idx);
        kw_entry_t e;
        e = '0;
        case (idx)
            6'd0:  e = '{{"FETCH",      40'd0}, 4'd5,  7'd0};
            6'd1:  e = '{{"FROM",       48'd0}, 4'd4,  7'd1};
            6'd2:  e = '{{"WHEN",       48'd0}, 4'd4,  7'd2};
            6'd3:  e = '{{"PUT",        56'd0}, 4'd3,  7'd3};
            6'd4:  e = '{{"INTO",       48'd0}, 4'd4,  7'd4};
            6'd5:  e = '{{"VALUES",     32'd0}, 4'd6,  7'd5};
            6'd6:  e = '{{"BUILD",      40'd0}, 4'd5,  7'd6};
            6'd7:  e = '{{"RELATION",   16'd0}, 4'd8,  7'd7};
            6'd8:  e = '{{"INDEX",      40'd0}, 4'd5,  7'd8};
            6'd9:  e = '{{"ON",         64'd0}, 4'd2,  7'd9};
            6'd10: e = '{{"REMOVE",     32'd0}, 4'd6,  7'd10};
            6'd11: e = '{{"AND",        56'd0}, 4'd3,  7'd46};
            6'd12: e = '{{"OR",         64'd0}, 4'd2,  7'd47};
            6'd13: e = '{{"NOT",        56'd0}, 4'd3,  7'd48};
            6'd14: e = '{{"INT",        56'd0}, 4'd3,  7'd49};
            6'd15: e = '{{"INTEGER",    24'd0}, 4'd7,  7'd49};
            6'd16: e = '{{"BOOL",       48'd0}, 4'd4,  7'd50};
            6'd17: e = '{{"BOOLEAN",    24'd0}, 4'd7,  7'd50};
            6'd18: e = '{{"TEXT",       48'd0}, 4'd4,  7'd51};
            6'd19: e = '{{"VARCHAR",    24'd0}, 4'd7,  7'd52};
            6'd20: e = '{{"FLOAT",      40'd0}, 4'd5,  7'd53};
            6'd21: e = '{{"DOUBLE",     32'd0}, 4'd6,  7'd53};
            6'd22: e = '{{"REAL",       48'd0}, 4'd4,  7'd53};
            6'd23: e = '{{"TRUE",       48'd0}, 4'd4,  7'd54};
            6'd24: e = '{{"FALSE",      40'd0}, 4'd5,  7'd55};
            6'd25: e = '{{"MODIFY",     32'd0}, 4'd6,  7'd11};
            6'd26: e = '{{"SET",        56'd0}, 4'd3,  7'd12};
            6'd27: e = '{{"DISCARD",    24'd0}, 4'd7,  7'd13};
            6'd28: e = '{{"SORT",       48'd0}, 4'd4,  7'd25};
            6'd29: e = '{{"BY",         64'd0}, 4'd2,  7'd26};
            6'd30: e = '{{"GROUP",      40'd0}, 4'd5,  7'd27};
            6'd31: e = '{{"HAVING",     32'd0}, 4'd6,  7'd28};
            6'd32: e = '{{"TAKE",       48'd0}, 4'd4,  7'd29};
            6'd33: e = '{{"SKIP",       48'd0}, 4'd4,  7'd30};
            6'd34: e = '{{"AS",         64'd0}, 4'd2,  7'd31};
            6'd35: e = '{{"ASC",        56'd0}, 4'd3,  7'd32};
            6'd36: e = '{{"DESC",       48'd0}, 4'd4,  7'd33};
            6'd37: e = '{{"LINK",       48'd0}, 4'd4,  7'd34};
            6'd38: e = '{{"LEFT",       48'd0}, 4'd4,  7'd35};
            6'd39: e = '{{"CROSS",      40'd0}, 4'd5,  7'd36};
            6'd40: e = '{{"IS",         64'd0}, 4'd2,  7'd37};
            6'd41: e = '{{"IN",         64'd0}, 4'd2,  7'd38};
            6'd42: e = '{{"BETWEEN",    24'd0}, 4'd7,  7'd39};
            6'd43: e = '{{"LIKE",       48'd0}, 4'd4,  7'd40};
            6'd44: e = '{{"NULL",       48'd0}, 4'd4,  7'd41};
            6'd45: e = '{{"START",      40'd0}, 4'd5,  7'd43};
            6'd46: e = '{{"SAVE",       48'd0}, 4'd4,  7'd44};
            6'd47: e = '{{"UNDO",       48'd0}, 4'd4,  7'd45};
            6'd48: e = '{{"RESHAPE",    24'd0}, 4'd7,  7'd14};
            6'd49: e = '{{"ADD",        56'd0}, 4'd3,  7'd15};
            6'd50: e = '{{"COLUMN",     32'd0}, 4'd6,  7'd16};
            6'd51: e = '{"REFERENCES",          4'd10, 7'd17};
            6'd52: e = '{{"FOREIGN",    24'd0}, 4'd7,  7'd18};
            6'd53: e = '{{"KEY",        56'd0}, 4'd3,  7'd19};
            6'd54: e = '{{"PRIMARY",    24'd0}, 4'd7,  7'd20};
            6'd55: e = '{{"UNIQUE",     32'd0}, 4'd6,  7'd21};
            6'd56: e = '{{"DEFAULT",    24'd0}, 4'd7,  7'd22};
            6'd57: e = '{{"CHECK",      40'd0}, 4'd5,  7'd23};
            6'd58: e = '{"UNIQUEONLY",          4'd10, 7'd24};
            6'd59: e = '{{"EXISTS",     32'd0}, 4'd6,  7'd42};
            default: e = '0;
        endcase
        return e;
    endfunction

endpackage

// ===== rtl/core/sqlkl_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqlkl_front: scanner front end
// Accepts one byte a cycle unless the queue is full, tracks position and mode,
// and pushes a bundle of up to three token records per byte into the queue.
// ----------------------------------------------------------------------------
module sqlkl_front #(
    parameter int MAX_KEYWORD_LEN = sqlkl_pkg::MAX_KEYWORD_LEN_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          char_code,
    input  logic                end_of_text,
    output logic                push,
    output sqlkl_pkg::bundle_t  push_data,
    input  logic                full
);

    localparam int BW = MAX_KEYWORD_LEN * 8;

    logic [3:0]        mode_reg, mode_next;
    logic [BW-1:0]     kbuf_reg, kbuf_next;
    logic [15:0]       line_reg, line_next;
    logic [15:0]       col_reg, col_next;
    logic [23:0]       off_reg, off_next;
    logic [15:0]       scol_reg, scol_next;
    logic [23:0]       soff_reg, soff_next;
    logic [15:0]       span_reg, span_next;
    logic [15:0]       dcol_reg, dcol_next;
    logic [23:0]       doff_reg, doff_next;

    logic              fire;
    logic [7:0]        c;
    logic [7:0]        cu;
    logic              is_alpha, is_digit, is_word, is_space;
    logic [6:0]        wkind;
    logic [79:0]       kw_text;
    logic [1:0]        n;
    sqlkl_pkg::token_t t [3];

    assign in_ready = !full;
    assign fire     = in_valid && in_ready;
    assign c        = char_code;
    assign cu       = (c >= 8'h61 && c <= 8'h7A) ? c - 8'd32 : c;
    assign is_alpha = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    assign is_digit = c >= 8'h30 && c <= 8'h39;
    assign is_word  = is_alpha || is_digit || c == 8'h5F;
    assign is_space = c == 8'h20 || c == 8'h09 || c == 8'h0D || c == 8'h0A;

    // keyword lookup on the buffered word, padded to table width
    always_comb begin
        kw_text = '0;
        for (int i = 0; i < 10; i++) begin
            if (i < MAX_KEYWORD_LEN && i < 16'(span_reg)) begin
                kw_text[79-8*i -: 8] = kbuf_reg[8*i +: 8];
            end
        end
        wkind = sqlkl_pkg::K_IDENT;
        if (span_reg <= 16'(MAX_KEYWORD_LEN) && span_reg <= 16'd10) begin
            for (int k = sqlkl_pkg::KW_COUNT - 1; k >= 0; k--) begin
                if (16'(sqlkl_pkg::kw_rom(6'(k)).len) == span_reg
                        && sqlkl_pkg::kw_rom(6'(k)).word == kw_text) begin
                    wkind = sqlkl_pkg::kw_rom(6'(k)).kind;
                end
            end
        end
    end

    function automatic logic [15:0] sat16(input logic [16:0] v);
        return v[16] ? 16'hFFFF : v[15:0];
    endfunction

    always_comb begin
        logic       do_flush, do_dispatch, nl;
        logic [6:0] k;
        mode_next = mode_reg;
        kbuf_next = kbuf_reg;
        line_next = line_reg;
        col_next  = col_reg;
        off_next  = off_reg;
        scol_next = scol_reg;
        soff_next = soff_reg;
        span_next = span_reg;
        dcol_next = dcol_reg;
        doff_next = doff_reg;
        n         = 2'd0;
        do_flush  = 1'b0;
        do_dispatch = 1'b0;
        nl        = 1'b0;
        k         = '0;
        for (int j = 0; j < 3; j++) begin
            t[j] = '0;
            t[j].line = line_reg;
        end

        if (end_of_text || fire == 1'b0) begin
            do_flush = end_of_text;
        end else begin
            case (mode_reg)
                sqlkl_pkg::M_IDENT: begin
                    if (is_word) begin
                        for (int i = 0; i < MAX_KEYWORD_LEN; i++) begin
                            if (16'(i) == span_reg) kbuf_next[8*i +: 8] = cu;
                        end
                        span_next = sat16({1'b0, span_reg} + 17'd1);
                    end else begin
                        do_flush = 1'b1;
                    end
                end
                sqlkl_pkg::M_NUM: begin
                    if (is_digit) begin
                        span_next = sat16({1'b0, span_reg} + 17'd1);
                    end else if (c == 8'h2E) begin
                        dcol_next = col_reg;
                        doff_next = off_reg;
                        mode_next = sqlkl_pkg::M_NUMDOT;
                    end else begin
                        do_flush = 1'b1;
                    end
                end
                sqlkl_pkg::M_NUMDOT: begin
                    if (is_digit) begin
                        span_next = sat16({1'b0, span_reg} + 17'd2);
                        mode_next = sqlkl_pkg::M_FRAC;
                    end else begin
                        do_flush = 1'b1;
                    end
                end
                sqlkl_pkg::M_FRAC: begin
                    if (is_digit) span_next = sat16({1'b0, span_reg} + 17'd1);
                    else do_flush = 1'b1;
                end
                sqlkl_pkg::M_STR: begin
                    span_next = sat16({1'b0, span_reg} + 17'd1);
                    if (c == 8'h27) mode_next = sqlkl_pkg::M_STRQ;
                end
                sqlkl_pkg::M_STRQ: begin
                    if (c == 8'h27) begin
                        span_next = sat16({1'b0, span_reg} + 17'd1);
                        mode_next = sqlkl_pkg::M_STR;
                    end else begin
                        do_flush = 1'b1;
                    end
                end
                sqlkl_pkg::M_LT, sqlkl_pkg::M_GT, sqlkl_pkg::M_BANG: begin
                    k = '0;
                    if (c == 8'h3D) begin
                        k = (mode_reg == sqlkl_pkg::M_LT) ? sqlkl_pkg::K_LEQ :
                            (mode_reg == sqlkl_pkg::M_GT) ? sqlkl_pkg::K_GEQ :
                            sqlkl_pkg::K_NEQ;
                    end else if (c == 8'h3E && mode_reg == sqlkl_pkg::M_LT) begin
                        k = sqlkl_pkg::K_NEQ;
                    end
                    if (k != '0) begin
                        t[0] = '{k, line_reg, scol_reg, soff_reg, 16'd2, 1'b0};
                        n = 2'd1;
                        span_next = 16'd2;
                        mode_next = sqlkl_pkg::M_IDLE;
                    end else begin
                        do_flush = 1'b1;
                    end
                end
                sqlkl_pkg::M_MINUS: begin
                    if (c == 8'h2D) mode_next = sqlkl_pkg::M_COMMENT;
                    else do_flush = 1'b1;
                end
                sqlkl_pkg::M_COMMENT: begin
                    if (c == 8'h0A) mode_next = sqlkl_pkg::M_IDLE;
                end
                default: do_dispatch = 1'b1;
            endcase
        end

        // flush the pending token
        if (do_flush) begin
            k = '0;
            case (mode_reg)
                sqlkl_pkg::M_IDENT:  k = wkind;
                sqlkl_pkg::M_NUM:    k = sqlkl_pkg::K_INT;
                sqlkl_pkg::M_NUMDOT: k = sqlkl_pkg::K_INT;
                sqlkl_pkg::M_FRAC:   k = sqlkl_pkg::K_FLOAT;
                sqlkl_pkg::M_STR:    k = sqlkl_pkg::K_UNKNOWN;
                sqlkl_pkg::M_STRQ:   k = sqlkl_pkg::K_STRING;
                sqlkl_pkg::M_LT:     k = sqlkl_pkg::K_LT;
                sqlkl_pkg::M_GT:     k = sqlkl_pkg::K_GT;
                sqlkl_pkg::M_BANG:   k = sqlkl_pkg::K_UNKNOWN;
                sqlkl_pkg::M_MINUS:  k = sqlkl_pkg::K_MINUS;
                default:             k = '0;
            endcase
            if (mode_reg != sqlkl_pkg::M_IDLE && mode_reg != sqlkl_pkg::M_COMMENT) begin
                t[0] = '{k, line_reg, scol_reg, soff_reg, span_reg, 1'b0};
                n = 2'd1;
                if (mode_reg == sqlkl_pkg::M_NUMDOT) begin
                    t[1] = '{sqlkl_pkg::K_DOT, line_reg, dcol_reg, doff_reg, 16'd1, 1'b0};
                    n = 2'd2;
                end
            end
            mode_next = sqlkl_pkg::M_IDLE;
            do_dispatch = !end_of_text;
        end

        // start a new token from the current byte
        if (do_dispatch) begin
            mode_next = sqlkl_pkg::M_IDLE;
            if (!is_space) begin
                k = '0;
                scol_next = col_reg;
                soff_next = off_reg;
                span_next = 16'd1;
                if (is_alpha || c == 8'h5F) begin
                    mode_next = sqlkl_pkg::M_IDENT;
                    kbuf_next[7:0] = cu;
                end else if (is_digit) mode_next = sqlkl_pkg::M_NUM;
                else if (c == 8'h27)  mode_next = sqlkl_pkg::M_STR;
                else if (c == 8'h3C)  mode_next = sqlkl_pkg::M_LT;
                else if (c == 8'h3E)  mode_next = sqlkl_pkg::M_GT;
                else if (c == 8'h21)  mode_next = sqlkl_pkg::M_BANG;
                else if (c == 8'h2D)  mode_next = sqlkl_pkg::M_MINUS;
                else begin
                    scol_next = scol_reg;
                    soff_next = soff_reg;
                    span_next = span_reg;
                    case (c)
                        8'h28:   k = sqlkl_pkg::K_LPAREN;
                        8'h29:   k = sqlkl_pkg::K_RPAREN;
                        8'h2C:   k = sqlkl_pkg::K_COMMA;
                        8'h3B:   k = sqlkl_pkg::K_SEMI;
                        8'h2A:   k = sqlkl_pkg::K_STAR;
                        8'h2B:   k = sqlkl_pkg::K_PLUS;
                        8'h2F:   k = sqlkl_pkg::K_SLASH;
                        8'h2E:   k = sqlkl_pkg::K_DOT;
                        8'h3D:   k = sqlkl_pkg::K_EQ;
                        default: k = sqlkl_pkg::K_UNKNOWN;
                    endcase
                    t[n] = '{k, line_reg, col_reg, off_reg, 16'd1, 1'b0};
                    n = n + 2'd1;
                end
            end
        end

        if (end_of_text) begin
            t[n] = '{sqlkl_pkg::K_EOF, line_reg, col_reg, off_reg, 16'd0, 1'b0};
            n = n + 2'd1;
            mode_next = sqlkl_pkg::M_IDLE;
            kbuf_next = '0;
            line_next = 16'd1;
            col_next  = 16'd1;
            off_next  = '0;
            scol_next = '0;
            soff_next = '0;
            span_next = '0;
            dcol_next = '0;
            doff_next = '0;
        end else begin
            nl = c == 8'h0A;
            line_next = nl ? sat16({1'b0, line_reg} + 17'd1) : line_reg;
            col_next  = nl ? 16'd1 : sat16({1'b0, col_reg} + 17'd1);
            off_next  = (off_reg == 24'hFFFFFF) ? off_reg : off_reg + 24'd1;
        end
        if (n != 2'd0) t[n - 2'd1].last = 1'b1;
    end

    assign push = fire;
    always_comb begin
        push_data.count = n;
        push_data.tok0  = t[0];
        push_data.tok1  = t[1];
        push_data.tok2  = t[2];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= sqlkl_pkg::M_IDLE;
            line_reg <= 16'd1;
            col_reg  <= 16'd1;
            off_reg  <= '0;
            span_reg <= '0;
        end else if (fire) begin
            mode_reg <= mode_next;
            line_reg <= line_next;
            col_reg  <= col_next;
            off_reg  <= off_next;
            span_reg <= span_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            kbuf_reg <= kbuf_next;
            scol_reg <= scol_next;
            soff_reg <= soff_next;
            dcol_reg <= dcol_next;
            doff_reg <= doff_next;
        end
    end

endmodule

// ===== rtl/core/sqlkl_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqlkl_back: bundle queue and token output stage
// Holds bundles in a short queue and hands out one token per out_ready cycle.
// ----------------------------------------------------------------------------
module sqlkl_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  sqlkl_pkg::bundle_t  push_data,
    output logic                full,
    output logic                out_valid,
    input  logic                out_ready,
    output sqlkl_pkg::token_t   out_tok
);

    localparam int DEPTH = 4;

    sqlkl_pkg::bundle_t q_reg [DEPTH];
    logic [1:0] wp_reg, rp_reg;
    logic [2:0] cnt_reg, cnt_next;
    logic [1:0] sel_reg;
    logic       pop, wr;
    sqlkl_pkg::bundle_t head;

    // empty bundles are never stored
    assign wr   = push && push_data.count != 2'd0;
    assign full = cnt_reg == 3'(DEPTH);
    assign head = q_reg[rp_reg];
    assign out_valid = cnt_reg != 3'd0;
    always_comb begin
        case (sel_reg)
            2'd0:    out_tok = head.tok0;
            2'd1:    out_tok = head.tok1;
            default: out_tok = head.tok2;
        endcase
    end
    assign pop = out_valid && out_ready && (sel_reg == head.count - 2'd1);
    assign cnt_next = cnt_reg + 3'(wr) - 3'(pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
            sel_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
            if (wr) wp_reg <= wp_reg + 2'd1;
            if (pop) begin
                rp_reg  <= rp_reg + 2'd1;
                sel_reg <= '0;
            end else if (out_valid && out_ready) begin
                sel_reg <= sel_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr) q_reg[wp_reg] <= push_data;
    end

endmodule

// ===== rtl/core/sql_keyword_lexer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sql_keyword_lexer: SQL source scanner producing token records
// Front end scans bytes, back end queues and emits the tokens.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel carries source bytes; tuser set marks end of text, which
//   flushes the pending token, emits EOF and returns all state to reset.
//   m_ channel carries token records, tlast set on the final token that
//   one input request causes; a request may cause none, one, two or three.
// Throughput: one byte per cycle while the queue has room; the output
//   side sends one token per cycle of m_axis_tready, so a burst of multi-token
//   requests fills the four-entry bundle queue, then throttles s_axis_tready.
// Order: a token is queued with the request that completes it and leaves m_
//   after older tokens (lookahead tokens complete on the next request).
// Reset: synchronous active low; clears mode, position counters and the
//   queue. The keyword buffer and token start registers need no reset.
// Stall: while m_axis_tready is low, tokens hold; the front keeps taking
//   bytes until the queue is full.
// ----------------------------------------------------------------------------
module sql_keyword_lexer #(
    parameter int MAX_KEYWORD_LEN = sqlkl_pkg::MAX_KEYWORD_LEN_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] char_code
    input  logic         s_axis_tuser,   // [0] end_of_text
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [6:0] token_kind, [22:7] token_line, [38:23] token_column,
    // [62:39] token_offset, [78:63] token_length, [79] zero fill
    output logic [79:0]  m_axis_tdata,
    output logic         m_axis_tlast
);

    logic                push, full;
    sqlkl_pkg::bundle_t  bundle;
    sqlkl_pkg::token_t   tok;

    sqlkl_front #(.MAX_KEYWORD_LEN(MAX_KEYWORD_LEN)) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .char_code  (s_axis_tdata),
        .end_of_text(s_axis_tuser),
        .push       (push),
        .push_data  (bundle),
        .full       (full)
    );

    sqlkl_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (bundle),
        .full      (full),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_tok   (tok)
    );

    assign m_axis_tdata = {1'b0, tok.length, tok.offset, tok.column, tok.line, tok.kind};
    assign m_axis_tlast = tok.last;

endmodule

// ===== rtl/core/sqlkl_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqlkl_checker: port-level checks of the lexer
// Watches the stream ports and flags illegal token records.
// ----------------------------------------------------------------------------
module sqlkl_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [79:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    // a stalled token holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("token changed under stall");

    // kinds stay in range
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[6:0] <= sqlkl_pkg::K_UNKNOWN)
        else $error("token kind out of range");

    // line numbers start at one
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[22:7] != 16'd0)
        else $error("token line zero");

    // end-of-text token has zero length and closes its run
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[6:0] == sqlkl_pkg::K_EOF
            |-> m_axis_tlast && m_axis_tdata[78:63] == 16'd0)
        else $error("bad end-of-text token");

endmodule

bind sql_keyword_lexer sqlkl_checker u_sqlkl_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
